FILE: hw/rtl/sdspi_pkg.sv
// -----------------------------------------------------------------------------
// SD SPI block transfer package
// Shared constants and codes for the SD card SPI-mode host engine.
// -----------------------------------------------------------------------------
`default_nettype none

package sdspi_pkg;

	localparam int unsigned SECTOR_BYTES   = 512;
	localparam int unsigned RESPONSE_TRIES = 10;
	localparam int unsigned INIT_RETRIES   = 255;

	// Request kinds.
	localparam logic [2:0] KIND_INIT   = 3'd0;
	localparam logic [2:0] KIND_READ   = 3'd1;
	localparam logic [2:0] KIND_WOPEN  = 3'd2;
	localparam logic [2:0] KIND_WBYTE  = 3'd3;
	localparam logic [2:0] KIND_WCLOSE = 3'd4;
	localparam logic [2:0] KIND_RX     = 3'd5;

	// Configuration register indexes.
	localparam logic [1:0] REG_BLOCK_ADDR = 2'd0;
	localparam logic [1:0] REG_TOKEN_LIM  = 2'd1;
	localparam logic [1:0] REG_BUSY_LIM   = 2'd2;

	// Command bytes.
	localparam logic [7:0] OP_IDLE_CMD = 8'h40;
	localparam logic [7:0] OP_OPCOND   = 8'h41;
	localparam logic [7:0] OP_CRC_OFF  = 8'h7B;
	localparam logic [7:0] OP_BLOCKLEN = 8'h50;
	localparam logic [7:0] OP_READ     = 8'h51;
	localparam logic [7:0] OP_WRITE    = 8'h58;

	localparam logic [7:0] CRC_CMD0   = 8'h95;
	localparam logic [7:0] CRC_OTHER  = 8'h01;
	localparam logic [7:0] TOKEN_DATA = 8'hFE;
	localparam logic [7:0] IDLE_BYTE  = 8'hFF;
	localparam logic [4:0] DRESP_MASK = 5'h1F;
	localparam logic [4:0] DRESP_OK   = 5'h05;

	typedef enum logic [4:0] {
		PH_IDLE, PH_DUMMY, PH_CMD_TX, PH_R1, PH_GAP, PH_TOKEN, PH_SKIP, PH_DATA,
		PH_TRAIL, PH_TAIL_OK, PH_TAIL_ERR, PH_WHDR1, PH_WHDR2, PH_WBYTE, PH_PAD,
		PH_DRESP, PH_BUSY
	} phase_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sd_spi_block_transfer_unit.sv
// -----------------------------------------------------------------------------
// SD SPI block transfer unit
// SPI-mode SD card host engine: at most one SPI byte per request, received bytes fed back.
// -----------------------------------------------------------------------------
//  Channel   Direction  Handshake       Payload
//  in        input      in_valid/stall  kind, sector, byte_offset, byte_count, data_byte
//  out       output     out_valid/stall spi_send_*, card_selected, read_*, done_res, status
//  cfg       input      cfg_we          cfg_index, cfg_data
//
// The engine state and the result register are updated at the edge where a request
// is accepted. A new request is taken every cycle while the result register is
// empty or being drained. Reset returns the phase, counters, configuration registers
// and out_valid to their power-up values; the result payload registers are not reset.
`default_nettype none

module sd_spi_block_transfer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  kind,
	input  wire logic [31:0] sector,
	input  wire logic [8:0]  byte_offset,
	input  wire logic [9:0]  byte_count,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             spi_send_valid,
	output logic [7:0]       spi_send_byte,
	output logic             card_selected,
	output logic             read_valid,
	output logic [7:0]       read_byte,
	output logic             done_res,
	output logic             status,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	sdspi_pkg::phase_t phase_q, phase_d;
	logic [47:0] cmd_q, cmd_d;
	logic [9:0]  bcnt_q, bcnt_d, skip_q, skip_d, dlv_q, dlv_d, wrem_q, wrem_d;
	logic [7:0]  retry_q, retry_d;
	logic [15:0] poll_q, poll_d;
	logic        sel_q, sel_d;
	logic        baddr_q;
	logic [15:0] tok_lim_q, busy_lim_q;

	logic        o_valid, o_cs, o_rvalid, o_done, o_status;
	logic [7:0]  o_byte, o_rbyte;
	logic        accept;

	assign in_stall = out_valid & out_stall;
	assign accept   = in_valid & ~in_stall;

	// Next-state and result logic for one request.
	always_comb begin
		logic [31:0] addr;
		logic [9:0]  ofs, cnt, room, bc_inc;
		logic [7:0]  cop, r, ndec, rdec;
		logic [15:0] pdec;
		phase_d = phase_q; cmd_d = cmd_q; bcnt_d = bcnt_q; skip_d = skip_q;
		dlv_d = dlv_q; wrem_d = wrem_q; retry_d = retry_q; poll_d = poll_q;
		sel_d = sel_q;
		o_valid = 1'b0; o_byte = '0; o_cs = 1'b0; o_rvalid = 1'b0; o_rbyte = '0;
		o_done = 1'b0; o_status = 1'b0;
		addr = baddr_q ? sector : {sector[22:0], 9'd0};
		ofs  = {1'b0, byte_offset};
		room = 10'(sdspi_pkg::SECTOR_BYTES) - ofs;
		cnt  = (byte_count == 10'd0) ? 10'd1 : byte_count;
		if (cnt > room) cnt = room;
		cop  = cmd_q[47:40];
		r    = data_byte;
		rdec = retry_q - 8'd1;
		pdec = poll_q - 16'd1;
		bc_inc = bcnt_q + 10'd1;
		ndec = '0;
		if (kind <= sdspi_pkg::KIND_WCLOSE) begin
			if (phase_q == sdspi_pkg::PH_IDLE) begin
				unique case (kind)
					sdspi_pkg::KIND_INIT: begin
						retry_d = 8'(sdspi_pkg::INIT_RETRIES);
						bcnt_d = 10'd10; phase_d = sdspi_pkg::PH_DUMMY;
						o_valid = 1'b1; o_byte = sdspi_pkg::IDLE_BYTE; o_cs = sel_q;
					end
					sdspi_pkg::KIND_READ, sdspi_pkg::KIND_WOPEN: begin
						if (kind == sdspi_pkg::KIND_READ) begin
							skip_d = ofs; dlv_d = cnt;
						end
						ndec = (kind == sdspi_pkg::KIND_READ) ? sdspi_pkg::OP_READ
							: sdspi_pkg::OP_WRITE;
						cmd_d = {ndec, addr, sdspi_pkg::CRC_OTHER};
						sel_d = 1'b1; bcnt_d = 10'd1; phase_d = sdspi_pkg::PH_CMD_TX;
						o_valid = 1'b1; o_byte = ndec; o_cs = 1'b1;
					end
					sdspi_pkg::KIND_WBYTE: begin
						if (wrem_q != 10'd0) begin
							wrem_d = wrem_q - 10'd1; phase_d = sdspi_pkg::PH_WBYTE;
							o_valid = 1'b1; o_byte = data_byte; o_cs = sel_q;
						end else begin
							o_done = 1'b1;
						end
					end
					default: begin
						bcnt_d = wrem_q + 10'd2; phase_d = sdspi_pkg::PH_PAD;
						o_valid = 1'b1; o_byte = 8'h00; o_cs = sel_q;
					end
				endcase
			end
		end else if (kind == sdspi_pkg::KIND_RX && phase_q != sdspi_pkg::PH_IDLE) begin
			// Default continuation: clock one idle byte at the current select.
			o_byte = sdspi_pkg::IDLE_BYTE; o_cs = sel_q;
			unique case (phase_q)
				sdspi_pkg::PH_DUMMY: begin
					bcnt_d = bcnt_q - 10'd1; o_valid = 1'b1;
					if (bcnt_d == 10'd0) begin
						cmd_d = {sdspi_pkg::OP_IDLE_CMD, 32'd0, sdspi_pkg::CRC_CMD0};
						sel_d = 1'b1; bcnt_d = 10'd1; phase_d = sdspi_pkg::PH_CMD_TX;
						o_byte = sdspi_pkg::OP_IDLE_CMD; o_cs = 1'b1;
					end
				end
				sdspi_pkg::PH_CMD_TX: begin
					o_valid = 1'b1;
					if (bcnt_q < 10'd6) begin
						unique case (bcnt_q[2:0])
							3'd1:    o_byte = cmd_q[39:32];
							3'd2:    o_byte = cmd_q[31:24];
							3'd3:    o_byte = cmd_q[23:16];
							3'd4:    o_byte = cmd_q[15:8];
							default: o_byte = cmd_q[7:0];
						endcase
						bcnt_d = bc_inc; o_cs = 1'b1;
					end else begin
						poll_d = 16'(sdspi_pkg::RESPONSE_TRIES);
						phase_d = sdspi_pkg::PH_R1;
					end
				end
				sdspi_pkg::PH_R1: begin
					if (r[7] && pdec != 16'd0) begin
						poll_d = pdec; o_valid = 1'b1;
					end else begin
						if (r[7]) poll_d = pdec;
						ndec = 8'h00;
						if (cop == sdspi_pkg::OP_IDLE_CMD) begin
							retry_d = rdec;
							if (rdec == 8'd0) begin
								phase_d = sdspi_pkg::PH_IDLE; o_done = 1'b1; o_status = 1'b1;
							end else if (r != 8'h01) begin
								bcnt_d = 10'd10; phase_d = sdspi_pkg::PH_DUMMY; o_valid = 1'b1;
							end else begin
								phase_d = sdspi_pkg::PH_GAP; o_valid = 1'b1;
							end
						end else if (cop == sdspi_pkg::OP_OPCOND) begin
							retry_d = rdec;
							if (rdec == 8'd0) begin
								phase_d = sdspi_pkg::PH_IDLE; o_done = 1'b1; o_status = 1'b1;
							end else begin
								ndec = (r != 8'h00) ? sdspi_pkg::OP_OPCOND
									: sdspi_pkg::OP_CRC_OFF;
								cmd_d = {ndec, 32'd0, sdspi_pkg::CRC_OTHER};
							end
						end else if (cop == sdspi_pkg::OP_CRC_OFF) begin
							ndec = sdspi_pkg::OP_BLOCKLEN;
							cmd_d = {ndec, 32'(sdspi_pkg::SECTOR_BYTES), sdspi_pkg::CRC_OTHER};
						end else if (cop == sdspi_pkg::OP_READ) begin
							o_valid = 1'b1;
							if (r == 8'h00) begin
								poll_d = tok_lim_q; phase_d = sdspi_pkg::PH_TOKEN;
							end else begin
								sel_d = 1'b0; phase_d = sdspi_pkg::PH_TAIL_ERR; o_cs = 1'b0;
							end
						end else if (cop == sdspi_pkg::OP_WRITE && r == 8'h00) begin
							phase_d = sdspi_pkg::PH_WHDR1; o_valid = 1'b1;
						end else begin
							phase_d = sdspi_pkg::PH_IDLE; o_done = 1'b1;
							o_status = (cop != sdspi_pkg::OP_BLOCKLEN);
						end
						if (ndec != 8'h00) begin
							sel_d = 1'b1; bcnt_d = 10'd1; phase_d = sdspi_pkg::PH_CMD_TX;
							o_valid = 1'b1; o_byte = ndec; o_cs = 1'b1;
						end
					end
				end
				sdspi_pkg::PH_GAP: begin
					retry_d = 8'(sdspi_pkg::INIT_RETRIES);
					cmd_d = {sdspi_pkg::OP_OPCOND, 32'd0, sdspi_pkg::CRC_OTHER};
					sel_d = 1'b1; bcnt_d = 10'd1; phase_d = sdspi_pkg::PH_CMD_TX;
					o_valid = 1'b1; o_byte = sdspi_pkg::OP_OPCOND; o_cs = 1'b1;
				end
				sdspi_pkg::PH_TOKEN: begin
					o_valid = 1'b1;
					if (r == sdspi_pkg::IDLE_BYTE) begin
						poll_d = pdec;
						if (pdec == 16'd0) begin
							sel_d = 1'b0; phase_d = sdspi_pkg::PH_TAIL_ERR; o_cs = 1'b0;
						end
					end else if (r == sdspi_pkg::TOKEN_DATA) begin
						bcnt_d = 10'(sdspi_pkg::SECTOR_BYTES + 2) - skip_q - dlv_q;
						phase_d = (skip_q != 10'd0) ? sdspi_pkg::PH_SKIP : sdspi_pkg::PH_DATA;
					end else begin
						sel_d = 1'b0; phase_d = sdspi_pkg::PH_TAIL_ERR; o_cs = 1'b0;
					end
				end
				sdspi_pkg::PH_SKIP: begin
					skip_d = skip_q - 10'd1; o_valid = 1'b1;
					if (skip_d == 10'd0) phase_d = sdspi_pkg::PH_DATA;
				end
				sdspi_pkg::PH_DATA: begin
					o_rvalid = 1'b1; o_rbyte = r; o_valid = 1'b1;
					dlv_d = dlv_q - 10'd1;
					if (dlv_d == 10'd0) phase_d = sdspi_pkg::PH_TRAIL;
				end
				sdspi_pkg::PH_TRAIL: begin
					bcnt_d = bcnt_q - 10'd1; o_valid = 1'b1;
					if (bcnt_d == 10'd0) begin
						sel_d = 1'b0; phase_d = sdspi_pkg::PH_TAIL_OK; o_cs = 1'b0;
					end
				end
				sdspi_pkg::PH_TAIL_OK, sdspi_pkg::PH_WBYTE: begin
					phase_d = sdspi_pkg::PH_IDLE; o_done = 1'b1;
				end
				sdspi_pkg::PH_TAIL_ERR: begin
					phase_d = sdspi_pkg::PH_IDLE; o_done = 1'b1; o_status = 1'b1;
				end
				sdspi_pkg::PH_WHDR1: begin
					phase_d = sdspi_pkg::PH_WHDR2; o_valid = 1'b1;
					o_byte = sdspi_pkg::TOKEN_DATA;
				end
				sdspi_pkg::PH_WHDR2: begin
					wrem_d = 10'(sdspi_pkg::SECTOR_BYTES);
					phase_d = sdspi_pkg::PH_IDLE; o_done = 1'b1;
				end
				sdspi_pkg::PH_PAD: begin
					bcnt_d = bcnt_q - 10'd1; o_valid = 1'b1;
					if (bcnt_d == 10'd0) phase_d = sdspi_pkg::PH_DRESP;
					else o_byte = 8'h00;
				end
				sdspi_pkg::PH_DRESP: begin
					o_valid = 1'b1;
					if ((r[4:0] & sdspi_pkg::DRESP_MASK) == sdspi_pkg::DRESP_OK) begin
						poll_d = busy_lim_q; phase_d = sdspi_pkg::PH_BUSY;
					end else begin
						sel_d = 1'b0; phase_d = sdspi_pkg::PH_TAIL_ERR; o_cs = 1'b0;
					end
				end
				sdspi_pkg::PH_BUSY: begin
					o_valid = 1'b1;
					if (r == sdspi_pkg::IDLE_BYTE || poll_q == 16'd0) begin
						sel_d = 1'b0; o_cs = 1'b0;
						phase_d = (r == sdspi_pkg::IDLE_BYTE && poll_q != 16'd0)
							? sdspi_pkg::PH_TAIL_OK : sdspi_pkg::PH_TAIL_ERR;
					end else begin
						poll_d = pdec;
					end
				end
				default: begin
				end
			endcase
			if (!o_valid) begin
				o_byte = '0; o_cs = 1'b0;
			end
		end
	end

	// Engine state, updated on each accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sdspi_pkg::PH_IDLE;
			cmd_q <= '0; bcnt_q <= '0; skip_q <= '0; dlv_q <= '0; wrem_q <= '0;
			retry_q <= '0; poll_q <= '0; sel_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			cmd_q <= cmd_d; bcnt_q <= bcnt_d; skip_q <= skip_d; dlv_q <= dlv_d;
			wrem_q <= wrem_d; retry_q <= retry_d; poll_q <= poll_d; sel_q <= sel_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baddr_q <= 1'b0; tok_lim_q <= 16'd40000; busy_lim_q <= 16'd5000;
		end else if (cfg_we) begin
			if (cfg_index == sdspi_pkg::REG_BLOCK_ADDR) baddr_q <= cfg_data[0];
			if (cfg_index == sdspi_pkg::REG_TOKEN_LIM)  tok_lim_q <= cfg_data;
			if (cfg_index == sdspi_pkg::REG_BUSY_LIM)   busy_lim_q <= cfg_data;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			spi_send_valid <= o_valid; spi_send_byte <= o_byte; card_selected <= o_cs;
			read_valid <= o_rvalid; read_byte <= o_rbyte; done_res <= o_done;
			status <= o_status;
		end
	end

endmodule

`default_nettype wire
